// ===== rtl/fcsg_pkg.sv =====
// Shared widths, defaults and control structs for the filled circle span generator.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package fcsg_pkg;

	localparam int CoordInW    = 15;
	localparam int RadiusW     = 5;
	localparam int SpanW       = 16;
	localparam int OffW        = 8;
	localparam int MaxIters    = 16;
	localparam int IterW       = $clog2(MaxIters);
	localparam int DefMaxRadius = 20;
	localparam int DefCoordBits = 16;

	typedef struct packed {
		logic       load;
		logic       emit;
		logic       step;
		logic       last;
		logic [1:0] phase;
	} fcsg_ctl_t;

	typedef struct packed {
		logic out_free;
		logic walk_done;
	} fcsg_sts_t;

endpackage

// ===== rtl/fcsg_cmd_if.sv =====
// Circle request channel: valid/ready handshake with center and radius.
// Depends on fcsg_pkg for field widths.
`timescale 1ns / 1ps

interface fcsg_cmd_if
	import fcsg_pkg::*;
;
	logic                       valid;
	logic                       ready;
	logic signed [CoordInW-1:0] center_x;
	logic signed [CoordInW-1:0] center_y;
	logic [RadiusW-1:0]         radius;

	modport source(output valid, output center_x, output center_y, output radius, input ready);
	modport sink(input valid, input center_x, input center_y, input radius, output ready);
endinterface

// ===== rtl/fcsg_span_if.sv =====
// Span request channel: valid/ready handshake with one horizontal span.
// Depends on fcsg_pkg for field widths.
`timescale 1ns / 1ps

interface fcsg_span_if
	import fcsg_pkg::*;
;
	logic                    valid;
	logic                    ready;
	logic signed [SpanW-1:0] span_left;
	logic signed [SpanW-1:0] span_right;
	logic signed [SpanW-1:0] span_row;
	logic                    last_span;

	modport source(output valid, output span_left, output span_right, output span_row,
		output last_span, input ready);
	modport sink(input valid, input span_left, input span_right, input span_row,
		input last_span, output ready);
endinterface

// ===== rtl/fcsg_dp.sv =====
// Datapath: latched circle, walker registers, next-step logic and the span output register.
// Depends on fcsg_pkg and fcsg_span_if; driven by fcsg_ctrl through fcsg_ctl_t.
`timescale 1ns / 1ps

module fcsg_dp
	import fcsg_pkg::*;
#(
	parameter int MAX_RADIUS = DefMaxRadius,
	parameter int COORD_BITS = DefCoordBits
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic signed [CoordInW-1:0] center_x,
	input  logic signed [CoordInW-1:0] center_y,
	input  logic [RadiusW-1:0]         radius,
	input  fcsg_ctl_t                  ctl,
	output fcsg_sts_t                  sts,
	fcsg_span_if.source                span
);

	localparam int MaskW = (COORD_BITS < SpanW) ? COORD_BITS : SpanW;
	localparam logic [SpanW:0] CoordMask = (17'd1 << MaskW) - 17'd1;
	localparam logic [RadiusW-1:0] RadLimit = RadiusW'(MAX_RADIUS);

	logic signed [CoordInW-1:0] cx_q, cy_q;
	logic signed [OffW-1:0]     r_q, ox_q, oy_q, d_q;
	logic signed [OffW-1:0]     ox_n, oy_n, d_n, two_ox, two_rmoy;
	logic [RadiusW-1:0]         r_clamp;
	logic signed [OffW-1:0]     r_ext;
	logic signed [OffW-1:0]     x_off, y_off;
	logic signed [SpanW:0]      cx_w, cy_w, xo_w, yo_w, left_w, right_w, row_w;
	logic                       out_valid_q, last_q;
	logic [SpanW-1:0]           left_q, right_q, row_q;

	assign r_clamp = (radius > RadLimit) ? RadLimit : radius;
	assign r_ext   = signed'({{(OffW-RadiusW){1'b0}}, r_clamp});

	always_comb begin
		two_ox   = ox_q <<< 1;
		two_rmoy = (r_q - oy_q) <<< 1;
		if (d_q >= two_ox) begin
			d_n  = d_q - two_ox - OffW'(1);
			ox_n = ox_q + OffW'(1);
			oy_n = oy_q;
		end else if (d_q < two_rmoy) begin
			d_n  = d_q + (oy_q <<< 1) - OffW'(1);
			ox_n = ox_q;
			oy_n = oy_q - OffW'(1);
		end else begin
			d_n  = d_q + ((oy_q - ox_q - OffW'(1)) <<< 1);
			ox_n = ox_q + OffW'(1);
			oy_n = oy_q - OffW'(1);
		end
	end

	assign sts.walk_done = (oy_n < ox_n);
	assign sts.out_free  = !out_valid_q || span.ready;

	always_comb begin
		case (ctl.phase)
			2'd0: begin
				x_off = oy_q;
				y_off = ox_q;
			end
			2'd1: begin
				x_off = ox_q;
				y_off = oy_q;
			end
			2'd2: begin
				x_off = ox_q;
				y_off = -oy_q;
			end
			2'd3: begin
				x_off = oy_q;
				y_off = -ox_q;
			end
			default: begin
				x_off = ox_q;
				y_off = oy_q;
			end
		endcase
	end

	assign cx_w    = {{(SpanW+1-CoordInW){cx_q[CoordInW-1]}}, cx_q};
	assign cy_w    = {{(SpanW+1-CoordInW){cy_q[CoordInW-1]}}, cy_q};
	assign xo_w    = {{(SpanW+1-OffW){x_off[OffW-1]}}, x_off};
	assign yo_w    = {{(SpanW+1-OffW){y_off[OffW-1]}}, y_off};
	assign left_w  = cx_w - xo_w;
	assign right_w = cx_w + xo_w;
	assign row_w   = cy_w + yo_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.emit) begin
			out_valid_q <= 1'b1;
		end else if (span.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cx_q <= center_x;
			cy_q <= center_y;
			r_q  <= r_ext;
			ox_q <= '0;
			oy_q <= r_ext;
			d_q  <= r_ext - OffW'(1);
		end else if (ctl.step) begin
			ox_q <= ox_n;
			oy_q <= oy_n;
			d_q  <= d_n;
		end
		if (ctl.emit) begin
			left_q  <= left_w[SpanW-1:0] & CoordMask[SpanW-1:0];
			right_q <= right_w[SpanW-1:0] & CoordMask[SpanW-1:0];
			row_q   <= row_w[SpanW-1:0] & CoordMask[SpanW-1:0];
			last_q  <= ctl.last;
		end
	end

	assign span.valid      = out_valid_q;
	assign span.span_left  = signed'(left_q);
	assign span.span_right = signed'(right_q);
	assign span.span_row   = signed'(row_q);
	assign span.last_span  = last_q;

endmodule

// ===== rtl/fcsg_ctrl.sv =====
// Controller: takes a circle request, sequences four spans per walker step, marks the last span.
// Depends on fcsg_pkg; drives fcsg_dp through fcsg_ctl_t.
`timescale 1ns / 1ps

module fcsg_ctrl
	import fcsg_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	output logic      cmd_ready,
	input  fcsg_sts_t sts,
	output fcsg_ctl_t ctl
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_WALK = 2'b10
	} state_t;

	state_t             state_q, state_d;
	logic [1:0]         phase_q;
	logic [IterW-1:0]   iter_q;
	logic               last_c;

	assign cmd_ready = (state_q == ST_IDLE);
	assign last_c    = (phase_q == 2'd3) && (sts.walk_done || iter_q == IterW'(MaxIters - 1));

	always_comb begin
		ctl.load  = 1'b0;
		ctl.emit  = 1'b0;
		ctl.step  = 1'b0;
		ctl.last  = last_c;
		ctl.phase = phase_q;
		state_d   = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					ctl.load = 1'b1;
					state_d  = ST_WALK;
				end
			end
			ST_WALK: begin
				if (sts.out_free) begin
					ctl.emit = 1'b1;
					ctl.step = (phase_q == 2'd3);
					if (last_c) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= '0;
			iter_q  <= '0;
		end else begin
			state_q <= state_d;
			if (ctl.load) begin
				phase_q <= '0;
				iter_q  <= '0;
			end else if (ctl.emit) begin
				phase_q <= phase_q + 2'd1;
				if (ctl.step) begin
					iter_q <= iter_q + IterW'(1);
				end
			end
		end
	end

endmodule

// ===== rtl/filled_circle_span_generator.sv =====
// Top level of the filled circle span generator: controller, datapath and checks.
// Depends on fcsg_pkg, fcsg_cmd_if, fcsg_span_if, fcsg_ctrl and fcsg_dp.
//
// Channel | Dir | Payload                                       | Handshake
// cmd     | in  | center_x, center_y, radius                    | valid/ready
// span    | out | span_left, span_right, span_row, last_span    | valid/ready
//
// Once a request is taken, spans leave one per cycle unless stalled, four per walker step.
// A circle gives 4 to 64 spans; radius 20 gives 60 spans.
// The single span output register sets the pace; the next request is taken once the
// last span is loaded, so it overlaps the final span waiting downstream.
// A stalled span output holds the walker. Reset returns the controller to idle.
`timescale 1ns / 1ps

module filled_circle_span_generator
	import fcsg_pkg::*;
#(
	parameter int MAX_RADIUS = DefMaxRadius,
	parameter int COORD_BITS = DefCoordBits
) (
	input logic         clk,
	input logic         arst_n,
	fcsg_cmd_if.sink    cmd,
	fcsg_span_if.source span
);

	fcsg_ctl_t ctl;
	fcsg_sts_t sts;

	fcsg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd.valid),
		.cmd_ready (cmd.ready),
		.sts       (sts),
		.ctl       (ctl)
	);

	fcsg_dp #(
		.MAX_RADIUS (MAX_RADIUS),
		.COORD_BITS (COORD_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.center_x (cmd.center_x),
		.center_y (cmd.center_y),
		.radius   (cmd.radius),
		.ctl      (ctl),
		.sts      (sts),
		.span     (span)
	);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.valid && cmd.ready) |=> !cmd.ready)
		else $error("request taken but controller did not start walking");

	a_span_held: assert property (@(posedge clk) disable iff (!arst_n)
		(span.valid && !span.ready) |=> (span.valid && $stable(span.span_left) &&
			$stable(span.span_row) && $stable(span.last_span)))
		else $error("stalled span request changed before it was taken");

	a_emit_only_walking: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.emit |-> !cmd.ready)
		else $error("span emitted while idle");

	a_last_on_step: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.emit && ctl.last) |-> ctl.step)
		else $error("final span not at the end of a walker step");

endmodule

// ===== verif/tb_filled_circle_span_generator.sv =====
// Self-checking testbench for filled_circle_span_generator: circle requests in, fill spans out.
// Depends on fcsg_pkg, fcsg_cmd_if, fcsg_span_if and the RTL of the block.
`timescale 1ns / 1ps

module tb_filled_circle_span_generator;
	import fcsg_pkg::*;

	localparam int ClampRadius = DefMaxRadius;
	localparam int CycleLimit = 400000;
	localparam int RandomCircles = 160;
	localparam int IdlePercent = 19;
	localparam int SettleCycles = 20;

	typedef struct {
		logic signed [CoordInW-1:0] cx;
		logic signed [CoordInW-1:0] cy;
		logic [RadiusW-1:0]         radius;
		bit                         drain;
	} circle_req_t;

	typedef struct {
		logic signed [SpanW-1:0] left;
		logic signed [SpanW-1:0] right;
		logic signed [SpanW-1:0] row;
		logic                    last;
	} span_t;

	logic clk;
	logic arst_n;

	fcsg_cmd_if  cmd_ch();
	fcsg_span_if span_ch();

	circle_req_t pending_circles[$];
	span_t       expected_spans[$];
	circle_req_t next_circle;
	circle_req_t taken_circle;
	span_t       want_span;
	logic        req_taken;
	bit          steady;
	int          error_count;
	int          circles_taken;
	int          clamped_taken;
	int          spans_checked;
	int          cycle_count;

	filled_circle_span_generator u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd_ch),
		.span  (span_ch)
	);

	task automatic report_span_error(input string what);
		$display("ERROR span %0d: %s", spans_checked, what);
		error_count++;
	endtask

	function automatic void add_span(input int left, input int right, input int row);
		span_t s;
		s.left = left[SpanW-1:0];
		s.right = right[SpanW-1:0];
		s.row = row[SpanW-1:0];
		s.last = 1'b0;
		expected_spans.push_back(s);
	endfunction

	function automatic void predict_circle_spans(input circle_req_t c);
		int x0;
		int y0;
		int r;
		int ox;
		int oy;
		int d;
		int iters;
		x0 = c.cx;
		y0 = c.cy;
		r = (c.radius > ClampRadius) ? ClampRadius : int'(c.radius);
		ox = 0;
		oy = r;
		d = r - 1;
		iters = 0;
		while (oy >= ox && iters < MaxIters) begin
			add_span(x0 - oy, x0 + oy, y0 + ox);
			add_span(x0 - ox, x0 + ox, y0 + oy);
			add_span(x0 - ox, x0 + ox, y0 - oy);
			add_span(x0 - oy, x0 + oy, y0 - ox);
			iters++;
			if (d >= 2 * ox) begin
				d -= 2 * ox + 1;
				ox += 1;
			end else if (d < 2 * (r - oy)) begin
				d += 2 * oy - 1;
				oy -= 1;
			end else begin
				d += 2 * (oy - ox - 1);
				oy -= 1;
				ox += 1;
			end
		end
		expected_spans[expected_spans.size() - 1].last = 1'b1;
	endfunction

	task automatic queue_circle(input int x, input int y, input int radius, input bit drain);
		circle_req_t c;
		c.cx = x[CoordInW-1:0];
		c.cy = y[CoordInW-1:0];
		c.radius = radius[RadiusW-1:0];
		c.drain = drain;
		pending_circles.push_back(c);
	endtask

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		cmd_ch.valid = 1'b0;
		cmd_ch.center_x = '0;
		cmd_ch.center_y = '0;
		cmd_ch.radius = '0;
		span_ch.ready = 1'b0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
	end

	assign steady = (circles_taken >= 50) && (circles_taken < 90);

	always @(negedge clk) begin
		if (!arst_n) begin
			cmd_ch.valid <= 1'b0;
		end else if (cmd_ch.valid && !req_taken) begin
			cmd_ch.valid <= 1'b1;
		end else if (pending_circles.size() == 0) begin
			cmd_ch.valid <= 1'b0;
		end else if (pending_circles[0].drain && expected_spans.size() != 0) begin
			cmd_ch.valid <= 1'b0;
		end else if (!steady && $urandom_range(0, 99) < IdlePercent) begin
			cmd_ch.valid <= 1'b0;
		end else begin
			next_circle = pending_circles.pop_front();
			cmd_ch.valid <= 1'b1;
			cmd_ch.center_x <= next_circle.cx;
			cmd_ch.center_y <= next_circle.cy;
			cmd_ch.radius <= next_circle.radius;
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			span_ch.ready <= 1'b0;
		end else begin
			span_ch.ready <= steady || ($urandom_range(0, 99) >= IdlePercent);
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			req_taken <= 1'b0;
		end else begin
			req_taken <= cmd_ch.valid && cmd_ch.ready;
			if (cmd_ch.valid && cmd_ch.ready) begin
				taken_circle.cx = cmd_ch.center_x;
				taken_circle.cy = cmd_ch.center_y;
				taken_circle.radius = cmd_ch.radius;
				taken_circle.drain = 1'b0;
				predict_circle_spans(taken_circle);
				circles_taken++;
				if (cmd_ch.radius > ClampRadius) begin
					clamped_taken++;
				end
			end
			if (span_ch.valid && span_ch.ready) begin
				if (expected_spans.size() == 0) begin
					report_span_error("span arrived with nothing expected");
				end else begin
					want_span = expected_spans.pop_front();
					if (span_ch.span_left !== want_span.left) begin
						report_span_error($sformatf("span_left %0d, expected %0d",
							span_ch.span_left, want_span.left));
					end
					if (span_ch.span_right !== want_span.right) begin
						report_span_error($sformatf("span_right %0d, expected %0d",
							span_ch.span_right, want_span.right));
					end
					if (span_ch.span_row !== want_span.row) begin
						report_span_error($sformatf("span_row %0d, expected %0d",
							span_ch.span_row, want_span.row));
					end
					if (span_ch.last_span !== want_span.last) begin
						report_span_error($sformatf("last_span %0b, expected %0b",
							span_ch.last_span, want_span.last));
					end
				end
				spans_checked++;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CycleLimit) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("end of test: mismatches");
			$finish;
		end
	end

	initial begin
		int pick;
		int radius;
		error_count = 0;
		circles_taken = 0;
		clamped_taken = 0;
		spans_checked = 0;
		cycle_count = 0;

		queue_circle(0, 0, 0, 1'b0);
		queue_circle(-16384, -16384, 0, 1'b0);
		queue_circle(16383, 16383, 0, 1'b0);
		queue_circle(5, -7, 1, 1'b0);
		queue_circle(-100, 100, 2, 1'b0);
		queue_circle(300, 200, 3, 1'b0);
		queue_circle(16383, 16383, 20, 1'b0);
		queue_circle(-16384, -16384, 20, 1'b0);
		queue_circle(16383, -16384, 21, 1'b0);
		queue_circle(-16384, 16383, 31, 1'b0);
		queue_circle(0, 0, 16, 1'b1);
		queue_circle(-1, -1, 10, 1'b0);
		queue_circle(1234, -4321, 19, 1'b0);
		queue_circle(-16384, 0, 30, 1'b1);

		for (int i = 0; i < RandomCircles; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				radius = $urandom_range(0, 7);
			end else if (pick < 90) begin
				radius = $urandom_range(8, ClampRadius);
			end else begin
				radius = $urandom_range(ClampRadius + 1, 31);
			end
			if ($urandom_range(0, 9) == 0) begin
				queue_circle(($urandom_range(0, 1) != 0) ? 16383 : -16384,
					($urandom_range(0, 1) != 0) ? 16383 : -16384, radius, i == 80);
			end else begin
				queue_circle($urandom(), $urandom(), radius, i == 80);
			end
		end

		@(posedge clk);
		while (pending_circles.size() != 0 || cmd_ch.valid) begin
			@(posedge clk);
		end
		while (expected_spans.size() != 0) begin
			@(posedge clk);
		end
		repeat (SettleCycles) @(posedge clk);

		if (expected_spans.size() != 0) begin
			report_span_error($sformatf("%0d spans never arrived", expected_spans.size()));
		end
		$display("Sent %0d circle requests (%0d with radius above the clamp limit).",
			circles_taken, clamped_taken);
		$display("Checked %0d spans in %0d cycles, %0d errors.",
			spans_checked, cycle_count, error_count);
		if (error_count == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
